// File: sv/ese_pkg.sv
// shared types and constants for the encoder speed estimator
package ese_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_PER_PULSE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_ALPHA   = 8'd1;

    localparam logic [31:0] DIST_PER_PULSE_RESET = 32'd16777;
    localparam logic [15:0] SMOOTH_ALPHA_RESET   = 16'd19661;

    localparam int unsigned SPEED_W  = 56;
    localparam int unsigned DIST_W   = 64;
    localparam int unsigned SCALED_W = 74;
    localparam int unsigned NUM_W    = SCALED_W - 8;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 216;

    typedef logic [1:0] status_code_t;
    localparam status_code_t STATUS_OK          = 2'd0;
    localparam status_code_t STATUS_ZERO_TIME   = 2'd1;
    localparam status_code_t STATUS_NOT_STARTED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIST,
        ST_SCALE,
        ST_DIV,
        ST_SAT,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_UPDATE,
        ST_OUT
    } ese_state_t;

    typedef struct packed {
        logic         load;
        logic         clear;
        logic         sample;
        logic         accum;
        logic         scale;
        logic         div_step;
        logic         sat;
        logic         diff;
        logic         mul_lo;
        logic         mul_hi;
        logic         update;
        logic         out_load;
        status_code_t status;
        logic         counter_clear;
    } ese_cmd_t;

    typedef struct packed {
        logic func;
        logic started;
        logic dt_zero;
        logic div_done;
        logic out_free;
    } ese_stat_t;

endpackage

// File: sv/ese_ctrl.sv
// controller state machine sequencing one word through the datapath
module ese_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ese_pkg::ese_stat_t stat,
    output ese_pkg::ese_cmd_t  cmd
);
    import ese_pkg::*;

    ese_state_t state_reg;
    ese_state_t state_next;
    status_code_t code_reg;
    status_code_t code_next;
    logic clr_reg;
    logic clr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            code_reg  <= STATUS_OK;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        code_next         = code_reg;
        clr_next          = clr_reg;
        cmd               = '0;
        cmd.status        = code_reg;
        cmd.counter_clear = clr_reg;
        s_tready          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                clr_next  = 1'b0;
                code_next = STATUS_OK;
                if (stat.func) begin
                    cmd.clear  = 1'b1;
                    clr_next   = 1'b1;
                    state_next = ST_OUT;
                end else if (!stat.started) begin
                    code_next  = STATUS_NOT_STARTED;
                    state_next = ST_OUT;
                end else if (stat.dt_zero) begin
                    code_next  = STATUS_ZERO_TIME;
                    state_next = ST_OUT;
                end else begin
                    cmd.sample = 1'b1;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                cmd.accum  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ese_datapath.sv
// datapath: state, accumulators, serial divider, filter multiply and output register
module ese_datapath #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ese_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ese_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [ese_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ese_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser,
    input  ese_pkg::ese_cmd_t                 cmd,
    output ese_pkg::ese_stat_t                stat
);
    import ese_pkg::*;

    localparam int unsigned CW = COUNTER_WIDTH;

    logic [31:0]          dpp_reg;
    logic [15:0]          alpha_reg;

    logic                 func_reg;
    logic [31:0]          now_reg;
    logic [15:0]          cnt_in_reg;

    logic                 started_reg;
    logic [CW-1:0]        prev_count_reg;
    logic [31:0]          prev_time_reg;
    logic [31:0]          count_sum_reg;
    logic [DIST_W-1:0]    dist_sum_reg;
    logic [SPEED_W-1:0]   latest_reg;
    logic [SPEED_W-1:0]   smooth_reg;

    logic signed [DIST_W-1:0] ddist_reg;
    logic [31:0]          dt_reg;
    logic                 neg_reg;
    logic [DIST_W-1:0]    mag_reg;
    logic [SCALED_W-1:0]  x_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [31:0]          rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic signed [SPEED_W:0] diff_reg;
    logic [47:0]          plo_reg;
    logic signed [41:0]   phi_reg;

    logic                 m_tvalid_reg;
    logic [1:0]           o_status_reg;
    logic [31:0]          o_count_reg;
    logic [DIST_W-1:0]    o_dist_reg;
    logic [SPEED_W-1:0]   o_raw_reg;
    logic [SPEED_W-1:0]   o_smooth_reg;
    logic                 o_clr_reg;

    logic [CW-1:0]        cur;
    logic [CW-1:0]        dm;
    logic signed [31:0]   delta;
    logic signed [65:0]   prod;
    logic [31:0]          dt;
    logic [SCALED_W-1:0]  dd_ext;
    logic [SCALED_W-1:0]  mag_ext;
    logic [SCALED_W-1:0]  x_final;
    logic [32:0]          shifted;
    logic [32:0]          trial;
    logic [SPEED_W-1:0]   sat_val;
    logic signed [73:0]   wsum;

    assign cur   = CW'(cnt_in_reg);
    assign dm    = cur - prev_count_reg;
    assign delta = 32'($signed(dm));
    assign prod  = delta * $signed({2'b00, dpp_reg});
    assign dt    = now_reg - prev_time_reg;

    assign dd_ext  = {{(SCALED_W-DIST_W){ddist_reg[DIST_W-1]}}, ddist_reg};
    assign mag_ext = {{(SCALED_W-DIST_W){1'b0}}, mag_reg};
    assign x_final = x_reg + (mag_ext << 3);

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, dt_reg};

    always_comb begin
        if (neg_reg) begin
            if (num_reg > {{(NUM_W-SPEED_W){1'b0}}, 1'b1, {(SPEED_W-1){1'b0}}}) begin
                sat_val = {1'b1, {(SPEED_W-1){1'b0}}};
            end else begin
                sat_val = {SPEED_W{1'b0}} - num_reg[SPEED_W-1:0];
            end
        end else begin
            if (num_reg > {{(NUM_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}}) begin
                sat_val = {1'b0, {(SPEED_W-1){1'b1}}};
            end else begin
                sat_val = num_reg[SPEED_W-1:0];
            end
        end
    end

    assign wsum = {phi_reg, 32'd0} + $signed({26'd0, plo_reg});

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpp_reg        <= DIST_PER_PULSE_RESET;
            alpha_reg      <= SMOOTH_ALPHA_RESET;
            started_reg    <= 1'b0;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            count_sum_reg  <= '0;
            dist_sum_reg   <= '0;
            latest_reg     <= '0;
            smooth_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_DIST_PER_PULSE: dpp_reg   <= cfg_data;
                    CFG_SMOOTH_ALPHA:   alpha_reg <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.clear) begin
                started_reg    <= 1'b1;
                prev_count_reg <= '0;
                prev_time_reg  <= now_reg;
                count_sum_reg  <= '0;
                dist_sum_reg   <= '0;
                latest_reg     <= '0;
                smooth_reg     <= '0;
            end
            if (cmd.sample) begin
                count_sum_reg  <= count_sum_reg + delta;
                prev_count_reg <= cur;
                prev_time_reg  <= now_reg;
            end
            if (cmd.accum) begin
                dist_sum_reg <= dist_sum_reg + ddist_reg;
            end
            if (cmd.sat) begin
                latest_reg <= sat_val;
            end
            if (cmd.update) begin
                smooth_reg <= smooth_reg + wsum[71:16];
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            cnt_in_reg <= s_tdata[47:32];
        end
        if (cmd.sample) begin
            ddist_reg <= prod[DIST_W-1:0];
            dt_reg    <= dt;
        end
        if (cmd.accum) begin
            neg_reg <= ddist_reg[DIST_W-1];
            mag_reg <= ddist_reg[DIST_W-1] ? DIST_W'(-ddist_reg) : ddist_reg;
            // 992 times the magnitude, the remaining 8 times is added next cycle
            x_reg   <= ddist_reg[DIST_W-1] ? (dd_ext << 5) - (dd_ext << 10)
                                           : (dd_ext << 10) - (dd_ext << 5);
        end
        if (cmd.scale) begin
            num_reg  <= x_final[SCALED_W-1:8];
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
            end else begin
                rem_reg <= shifted[31:0];
            end
            num_reg  <= {num_reg[NUM_W-2:0], ~trial[32]};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.diff) begin
            diff_reg <= $signed({latest_reg[SPEED_W-1], latest_reg})
                      - $signed({smooth_reg[SPEED_W-1], smooth_reg});
        end
        if (cmd.mul_lo) begin
            plo_reg <= alpha_reg * diff_reg[31:0];
        end
        if (cmd.mul_hi) begin
            phi_reg <= $signed({1'b0, alpha_reg}) * $signed(diff_reg[SPEED_W:32]);
        end
        if (cmd.out_load) begin
            o_status_reg <= cmd.status;
            o_count_reg  <= count_sum_reg;
            o_dist_reg   <= dist_sum_reg;
            o_raw_reg    <= latest_reg;
            o_smooth_reg <= smooth_reg;
            o_clr_reg    <= cmd.counter_clear;
        end
    end

    assign stat.func     = func_reg;
    assign stat.started  = started_reg;
    assign stat.dt_zero  = (dt == 32'd0);
    assign stat.div_done = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {7'd0, o_clr_reg, o_smooth_reg, o_raw_reg, o_dist_reg, o_count_reg};

endmodule

// File: sv/encoder_speed_estimator.sv
// top level of the encoder speed estimator: controller plus datapath
// one word at a time; a clear or rejected word goes from decode straight to the output state,
// while an updating sample passes the 66-step serial divider before its result is loaded
// the next word is taken only after its result is loaded; loading waits while an output is pending
// and not taken; the output register holds a result while the next word is taken
// synchronous active-low reset: defaults in the configuration registers, all totals zero, not started
module encoder_speed_estimator #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ese_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ese_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms [31:0], counter_value [47:32]
    input  logic [ese_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pulse total [31:0], total_distance [95:32], raw_speed [151:96],
    // smooth_speed [207:152], counter_clear [208], zero fill [215:209]
    output logic [ese_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [1:0]                      m_tuser
);
    import ese_pkg::*;

    ese_cmd_t  cmd;
    ese_stat_t stat;

    ese_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ese_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
